@@ src/alrt_pkg.sv @@
// ----------------------------------------------------------------------------
// Audio level range tracker package
// Widths, reset values and register indexes shared by the tracker.
// ----------------------------------------------------------------------------
package alrt_pkg;

   localparam int MAG_W      = 10;
   localparam int HIGH_W     = 11;
   localparam int CSR_IDX_W  = 2;

   typedef logic [MAG_W-1:0]     mag_type;
   typedef logic [HIGH_W-1:0]    high_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_CENTER_OFFSET = 2'd0;
   localparam csr_idx_type CSR_NOISE_FLOOR   = 2'd1;
   localparam csr_idx_type CSR_MIN_SPAN      = 2'd2;

   localparam mag_type  RST_CENTER_OFFSET = 10'd512;
   localparam mag_type  RST_NOISE_FLOOR   = 10'd10;
   localparam mag_type  RST_MIN_SPAN      = 10'd64;
   localparam mag_type  RST_LEVEL         = 10'd12;
   localparam mag_type  RST_LOW_AVERAGE   = 10'd0;
   localparam high_type RST_HIGH_AVERAGE  = 11'd512;

endpackage

@@ src/audio_level_range_tracker.sv @@
// ----------------------------------------------------------------------------
// Audio level range tracker
// Gated sample magnitude, running level and slow averages of the window range.
// ----------------------------------------------------------------------------
// Each accepted sample occupies the block from the cycle of the transfer until
// its result is registered: the block writes the gated magnitude into the
// window RAM, scans the window through the RAM's single read port, then
// finishes the scan, corrects the span and updates the averages. The averaging
// step waits while an earlier result is still stalled. A finished result waits
// in the output register while the next sample is taken. The window starts at
// zero after reset through per-entry valid bits, so no clearing pass is needed.
module audio_level_range_tracker #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  alrt_pkg::mag_type     req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output alrt_pkg::mag_type     rsp_level,
   output alrt_pkg::mag_type     rsp_min_average,
   output alrt_pkg::high_type    rsp_max_average,
   input  logic                  csr_write,
   input  alrt_pkg::csr_idx_type csr_index,
   input  alrt_pkg::mag_type     csr_wdata
);
   import alrt_pkg::*;

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_SPAN  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]              state_ff, state_in;
   mag_type                 center_ff, noise_ff, span_ff;
   mag_type                 sample_ff;
   mag_type                 level_ff, level_in;
   mag_type                 low_avg_ff;
   high_type                high_avg_ff;
   logic [AW-1:0]           wr_ptr_ff;
   logic [AW-1:0]           rd_ptr_ff;
   logic [WINDOW_DEPTH-1:0] valid_ff;
   logic                    rd_pend_ff;
   logic                    rd_valid_ff;
   mag_type                 lo_ff;
   high_type                hi_ff;
   logic                    rsp_valid_ff;
   mag_type                 rsp_level_ff, rsp_min_ff;
   high_type                rsp_max_ff;

   mag_type                 abs_diff, mag;
   logic [12:0]             level_sum;
   logic [15:0]             low_sum;
   logic [16:0]             high_sum;
   mag_type                 ram_rd_data, entry;
   logic                    ram_wr_en;
   high_type                hi_fix;
   logic                    out_free;

   alrt_ram #(
      .WIDTH(MAG_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(wr_ptr_ff),
      .wr_data(mag),
      .rd_addr(rd_ptr_ff),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      abs_diff  = (sample_ff >= center_ff) ? sample_ff - center_ff : center_ff - sample_ff;
      mag       = (abs_diff > noise_ff) ? abs_diff - noise_ff : '0;
      level_sum = {level_ff, 3'b000} - 13'(level_ff) + 13'(mag);
      level_in  = level_sum[12:3];
      entry     = rd_valid_ff ? ram_rd_data : '0;
      hi_fix    = ((hi_ff - 11'(lo_ff)) < 11'(span_ff)) ? 11'(lo_ff) + 11'(span_ff) : hi_ff;
      low_sum   = {low_avg_ff, 6'b000000} - 16'(low_avg_ff) + 16'(lo_ff);
      high_sum  = {high_avg_ff, 6'b000000} - 17'(high_avg_ff) + 17'(hi_ff);
      out_free  = !rsp_valid_ff || !rsp_stall;
      ram_wr_en = (state_ff == S_WRITE);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_WRITE;
         S_WRITE: state_in = S_SCAN;
         S_SCAN:  if (rd_ptr_ff == LAST_ADDR) state_in = S_DRAIN;
         S_DRAIN: state_in = S_SPAN;
         S_SPAN:  state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         center_ff    <= RST_CENTER_OFFSET;
         noise_ff     <= RST_NOISE_FLOOR;
         span_ff      <= RST_MIN_SPAN;
         level_ff     <= RST_LEVEL;
         low_avg_ff   <= RST_LOW_AVERAGE;
         high_avg_ff  <= RST_HIGH_AVERAGE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == S_SCAN);
         if (csr_write) begin
            unique case (csr_index)
               CSR_CENTER_OFFSET: center_ff <= csr_wdata;
               CSR_NOISE_FLOOR:   noise_ff  <= csr_wdata;
               CSR_MIN_SPAN:      span_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_WRITE) begin
            level_ff           <= level_in;
            valid_ff[wr_ptr_ff] <= 1'b1;
            wr_ptr_ff          <= (wr_ptr_ff == LAST_ADDR) ? '0 : wr_ptr_ff + AW'(1);
            rd_ptr_ff          <= '0;
         end
         if (state_ff == S_SCAN) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == S_OUT && out_free) begin
            low_avg_ff   <= low_sum[15:6];
            high_avg_ff  <= high_sum[16:6];
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= valid_ff[rd_ptr_ff];
      if (req_valid && !req_stall) begin
         sample_ff <= req_sample;
      end
      if (state_ff == S_WRITE) begin
         lo_ff <= '1;
         hi_ff <= '0;
      end else if (rd_pend_ff) begin
         if (entry < lo_ff) begin
            lo_ff <= entry;
         end
         if (11'(entry) > hi_ff) begin
            hi_ff <= 11'(entry);
         end
      end else if (state_ff == S_SPAN) begin
         hi_ff <= hi_fix;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_level_ff <= level_ff;
         rsp_min_ff   <= low_sum[15:6];
         rsp_max_ff   <= high_sum[16:6];
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_min_average = rsp_min_ff;
   assign rsp_max_average = rsp_max_ff;

   // An accepted transfer always starts the window write in the next cycle.
   a_accept_write: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_WRITE))
      else $error("accepted transfer did not start a window write");

   // A new result only appears after the averaging step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside the averaging step");

   // The finished scan always leaves the minimum at or below the maximum.
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPAN) |-> (11'(lo_ff) <= hi_ff))
      else $error("window scan left minimum above maximum");

   // The scan issues its last read just before the drain step.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> ($past(rd_ptr_ff) == LAST_ADDR))
      else $error("window scan ended early");

   // The slow maximum average cannot reach the top of its range.
   a_high_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (high_avg_ff != '1))
      else $error("maximum average out of range");

endmodule

@@ src/alrt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module alrt_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
